// ----- design/dosq_pkg.sv -----
// Shared types, constants and the sort-key compare for the draw-order sort queue.
`timescale 1ns / 1ps
`default_nettype none

package dosq_pkg;

    localparam int QUEUE_DEPTH = 256;

    localparam logic [15:0] THRESHOLD_RESET = 16'd32736;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [11:0]        tag;
        logic signed [7:0]  order;
        logic signed [31:0] depth;
        logic               transp;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } cell_ctl_t;

    // a must be drawn strictly before b
    function automatic logic precedes(input entry_t a, input entry_t b);
        logic r;
        if (a.order != b.order)
            r = (a.order < b.order);
        else if (a.transp != b.transp)
            r = !a.transp;
        else if (!a.transp)
            r = (a.depth < b.depth);
        else
            r = (a.depth > b.depth);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/dosq_req_if.sv -----
// Request channel: valid/ready handshake with the submit/pop/clear payload.
`timescale 1ns / 1ps
`default_nettype none

interface dosq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [11:0] entry_tag;
    logic signed [7:0]  draw_order;
    logic signed [31:0] depth;
    logic        alpha_blend_texture;
    logic [15:0] mesh_alpha;
    logic [15:0] tint_alpha;
    logic [15:0] fade_factor;
    logic        glow;

    modport source (
        output valid, op, entry_tag, draw_order, depth, alpha_blend_texture,
               mesh_alpha, tint_alpha, fade_factor, glow,
        input  ready
    );

    modport sink (
        input  valid, op, entry_tag, draw_order, depth, alpha_blend_texture,
               mesh_alpha, tint_alpha, fade_factor, glow,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/dosq_rsp_if.sv -----
// Response channel: valid/ready handshake with the status and popped entry.
`timescale 1ns / 1ps
`default_nettype none

interface dosq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] out_tag;
    logic signed [7:0]  out_order;
    logic signed [31:0] out_depth;
    logic        is_transparent;
    logic        last;

    modport source (
        output valid, status, out_tag, out_order, out_depth, is_transparent, last,
        input  ready
    );

    modport sink (
        input  valid, status, out_tag, out_order, out_depth, is_transparent, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/dosq_cell.sv -----
// One queue slot: holds an entry, shifts right on insert, left on pop.
`timescale 1ns / 1ps
`default_nettype none

module dosq_cell
    import dosq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire entry_t    new_entry,
    input  wire entry_t    left_entry,
    input  wire logic      left_valid,
    input  wire logic      left_hit,
    input  wire entry_t    right_entry,
    input  wire logic      right_valid,
    output entry_t         entry,
    output logic           valid,
    output logic           hit
);

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;

    // new entry lands here or further left; empty slots always hit
    assign hit = !valid_reg || precedes(new_entry, entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        priority if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.ins)
        begin
            if (hit)
            begin
                if (left_hit)
                begin
                    entry_next = left_entry;
                    valid_next = left_valid;
                end
                else
                begin
                    entry_next = new_entry;
                    valid_next = 1'b1;
                end
            end
        end
        else if (ctl.pop)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ----- design/dosq_chain.sv -----
// Row of QUEUE_DEPTH cells; cell 0 holds the next entry to draw.
`timescale 1ns / 1ps
`default_nettype none

module dosq_chain
    import dosq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire entry_t    new_entry,
    output entry_t         head_entry,
    output logic           head_valid,
    output logic           second_valid,
    output logic           tail_valid
);

    entry_t ent [QUEUE_DEPTH];
    logic   vld [QUEUE_DEPTH];
    logic   hit [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t l_ent, r_ent;
        logic   l_vld, l_hit, r_vld;

        if (i == 0)
        begin : g_first
            assign l_ent = '0;
            assign l_vld = 1'b0;
            assign l_hit = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_ent = ent[i-1];
            assign l_vld = vld[i-1];
            assign l_hit = hit[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_ent = '0;
            assign r_vld = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_ent = ent[i+1];
            assign r_vld = vld[i+1];
        end

        dosq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (l_ent),
            .left_valid  (l_vld),
            .left_hit    (l_hit),
            .right_entry (r_ent),
            .right_valid (r_vld),
            .entry       (ent[i]),
            .valid       (vld[i]),
            .hit         (hit[i])
        );
    end

    assign head_entry   = ent[0];
    assign head_valid   = vld[0];
    assign second_valid = vld[1];
    assign tail_valid   = vld[QUEUE_DEPTH-1];

endmodule

`default_nettype wire

// ----- design/draw_order_sort_queue_top.sv -----
// Top level of the draw-order sort queue: request stage, cell row, response register.
//
//   channel   dir   handshake      contents
//   req       in    valid/ready    op, entry tag, order, depth, alpha/glow flags
//   rsp       out   valid/ready    status, popped entry, transparency, last flag
//   cfg       in    cfg_we         opaque threshold, Q1.15
//
// A request is captured in the request register and goes to the cell row once the
// response register can take its result; no new request is taken until then.
// Insert, pop and clear update all cells of the row at once for any fill level.
// Reset empties the queue and loads the threshold with 32736.
// A stalled response holds the request register, and req.ready drops until it moves.
`timescale 1ns / 1ps
`default_nettype none

module draw_order_sort_queue_top
    import dosq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dosq_req_if.sink   req,
    dosq_rsp_if.source rsp,
    input  wire logic  cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    logic [15:0] thresh_reg;
    logic        cmd_valid_reg;
    op_t         cmd_op_reg;
    entry_t      cmd_entry_reg;
    logic        out_valid_reg;
    status_t     status_reg, status_next;
    entry_t      out_entry_reg, out_entry_next;
    logic        last_reg, last_next;

    entry_t    in_entry;
    logic      accept;
    logic      fire;
    cell_ctl_t ctl;
    entry_t    head_entry;
    logic      head_valid, second_valid, tail_valid;

    assign req.ready = !cmd_valid_reg;
    assign accept    = req.valid && req.ready;
    assign fire      = cmd_valid_reg && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        in_entry.tag    = req.entry_tag;
        in_entry.order  = req.draw_order;
        in_entry.depth  = req.depth;
        in_entry.transp = req.alpha_blend_texture || req.glow
                       || (req.mesh_alpha  < thresh_reg)
                       || (req.tint_alpha  < thresh_reg)
                       || (req.fade_factor < thresh_reg);
    end

    always_comb
    begin
        ctl            = '0;
        status_next    = ST_OK;
        out_entry_next = '0;
        last_next      = 1'b0;
        unique case (cmd_op_reg)
            OP_SUBMIT:
            begin
                out_entry_next.transp = cmd_entry_reg.transp;
                if (tail_valid)
                    status_next = ST_FULL;
                else
                    ctl.ins = fire;
            end
            OP_POP:
            begin
                if (!head_valid)
                    status_next = ST_EMPTY;
                else
                begin
                    out_entry_next = head_entry;
                    last_next      = !second_valid;
                    ctl.pop        = fire;
                end
            end
            OP_CLEAR:
            begin
                ctl.clr = fire;
            end
            OP_NONE:
            begin
                ctl = '0;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    dosq_chain u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .new_entry    (cmd_entry_reg),
        .head_entry   (head_entry),
        .head_valid   (head_valid),
        .second_valid (second_valid),
        .tail_valid   (tail_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESHOLD_RESET;
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thresh_reg <= cfg_wdata;
            if (accept)
                cmd_valid_reg <= 1'b1;
            else if (fire)
                cmd_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_op_reg    <= op_t'(req.op);
            cmd_entry_reg <= in_entry;
        end
        if (fire)
        begin
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
            last_reg      <= last_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.out_tag        = out_entry_reg.tag;
    assign rsp.out_order      = out_entry_reg.order;
    assign rsp.out_depth      = out_entry_reg.depth;
    assign rsp.is_transparent = out_entry_reg.transp;
    assign rsp.last           = last_reg;

`ifndef SYNTHESIS
    // cells fill from the head, so a full row has a valid head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |-> head_valid)
        else $error("tail cell valid while head cell empty");

    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("executed request produced no response");

    a_accept_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cmd_valid_reg)
        else $error("accepted request not held");

    a_row_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(head_valid) && $stable(tail_valid))
        else $error("cell row changed without an executed request");
`endif

endmodule

`default_nettype wire
